[rtl/saae_pkg.sv]
// -----------------------------------------------------------------------------
// saae_pkg
// Shared constants for the STUN attribute address extractor.
// -----------------------------------------------------------------------------
package saae_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned ATTR_TYPE_W  = 16;
   localparam int unsigned PORT_W       = 16;
   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned RSP_DATA_W   = PORT_W + ADDR_W;
   localparam int unsigned HDR_COUNT_W  = 5;
   localparam int unsigned ATTR_LEN_W   = 16;
   // family byte plus port plus address; the first value byte is never used
   localparam int unsigned VALUE_W      = 56;

   localparam logic [HDR_COUNT_W-1:0] MSG_HEADER_BYTES = 5'd20;
   localparam logic [ATTR_LEN_W-1:0]  ADDR_VALUE_LEN   = 16'd8;
   localparam logic [BYTE_W-1:0]      FAMILY_IPV4      = 8'd1;
   localparam logic [ATTR_TYPE_W-1:0] ATTR_MAPPED_ADDR = 16'h0001;
   localparam logic [ATTR_TYPE_W-1:0] ATTR_CHANGED_ADDR = 16'h0005;

endpackage

[rtl/stun_attribute_address_extractor_core.sv]
// -----------------------------------------------------------------------------
// stun_attribute_address_extractor_core
// Walks a STUN message byte by byte and extracts the IPv4 port and address
// of the first attribute of the configured type.
// -----------------------------------------------------------------------------
// Channel | Direction | tdata (low bit up)              | tuser / tlast
// req     | in        | message_byte [7:0]              | tlast = final_byte
// rsp     | out       | port_number [15:0], ipv4 [47:16] | tuser[0] = found
// csr     | in        | attribute_type [15:0]           | -
//
// One byte is taken every cycle while req_tready is high; the result appears in the
// cycle after the transfer of the final byte, held in a single output register.
// req_tready drops only while a result waits and rsp_tready is low.
// Reset clears the parse state and the result valid; attribute_type
// returns to 1 (mapped address).
// -----------------------------------------------------------------------------
module stun_attribute_address_extractor_core
   import saae_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] message_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] port_number, [47:16] ipv4_address
   output logic                   rsp_tuser,   // [0] found
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ATTR_TYPE_W-1:0] csr_data
);

   typedef enum logic [1:0] {
      PH_HEADER   = 2'd0,
      PH_ATTR_HDR = 2'd1,
      PH_VALUE    = 2'd2
   } phase_type;

   logic [ATTR_TYPE_W-1:0] attr_type_ff;
   phase_type              phase_ff, phase_in;
   logic [HDR_COUNT_W-1:0] hdr_count_ff, hdr_count_in;
   logic [31:0]            attr_hdr_ff, attr_hdr_in;
   logic [1:0]             hdr_idx_ff, hdr_idx_in;
   logic [ATTR_LEN_W-1:0]  remain_ff, remain_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic                   match_ff, match_in;
   logic                   decided_ff, decided_in;

   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   logic                   req_xfer;
   logic                   found_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      attr_hdr_in  = attr_hdr_ff;
      hdr_idx_in   = hdr_idx_ff;
      remain_in    = remain_ff;
      value_in     = value_ff;
      match_in     = match_ff;
      decided_in   = decided_ff;
      if (!decided_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               hdr_count_in = hdr_count_ff + 1'b1;
               if (hdr_count_in >= MSG_HEADER_BYTES) begin
                  phase_in = PH_ATTR_HDR;
               end
            end
            PH_ATTR_HDR: begin
               attr_hdr_in = {attr_hdr_ff[23:0], req_tdata};
               if (hdr_idx_ff == 2'd3) begin
                  hdr_idx_in = 2'd0;
                  match_in   = (attr_hdr_in[31:16] == attr_type_ff);
                  remain_in  = attr_hdr_in[15:0];
                  value_in   = '0;
                  if (match_in && remain_in != ADDR_VALUE_LEN) begin
                     // matching type with the wrong length decides not found
                     decided_in = 1'b1;
                     match_in   = 1'b0;
                  end else if (remain_in != '0) begin
                     phase_in = PH_VALUE;
                  end
               end else begin
                  hdr_idx_in = hdr_idx_ff + 1'b1;
               end
            end
            PH_VALUE: begin
               value_in  = {value_ff[VALUE_W-BYTE_W-1:0], req_tdata};
               remain_in = remain_ff - 1'b1;
               if (remain_in == '0) begin
                  if (match_ff) begin
                     decided_in = 1'b1;
                     match_in   = (value_in[VALUE_W-1 -: BYTE_W] == FAMILY_IPV4);
                  end else begin
                     phase_in = PH_ATTR_HDR;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      found_in = decided_in && match_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_type_ff <= ATTR_MAPPED_ADDR;
         phase_ff     <= PH_HEADER;
         hdr_count_ff <= '0;
         attr_hdr_ff  <= '0;
         hdr_idx_ff   <= '0;
         remain_ff    <= '0;
         value_ff     <= '0;
         match_ff     <= 1'b0;
         decided_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            attr_type_ff <= csr_data;
         end
         if (req_xfer && req_tlast) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_xfer) begin
            if (req_tlast) begin
               rsp_found_ff <= found_in;
               // port in the low half, address above it
               rsp_data_ff  <= found_in ? {value_in[ADDR_W-1:0], value_in[ADDR_W +: PORT_W]}
                                        : '0;
               phase_ff     <= PH_HEADER;
               hdr_count_ff <= '0;
               attr_hdr_ff  <= '0;
               hdr_idx_ff   <= '0;
               remain_ff    <= '0;
               value_ff     <= '0;
               match_ff     <= 1'b0;
               decided_ff   <= 1'b0;
            end else begin
               phase_ff     <= phase_in;
               hdr_count_ff <= hdr_count_in;
               attr_hdr_ff  <= attr_hdr_in;
               hdr_idx_ff   <= hdr_idx_in;
               remain_ff    <= remain_in;
               value_ff     <= value_in;
               match_ff     <= match_in;
               decided_ff   <= decided_in;
            end
         end
      end
   end

endmodule

[rtl/saae_checker.sv]
// -----------------------------------------------------------------------------
// saae_checker
// Port-level checks on the STUN attribute address extractor.
// -----------------------------------------------------------------------------
module saae_checker
   import saae_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic                   rsp_tuser
);

   // a held result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // not found carries zero port and address
   a_zero_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("non-zero payload on a not-found result");

   // the final byte transfer always yields a result
   a_result_on_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no result after final byte");

   // a non-final byte never creates a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready && req_tlast) |=> !rsp_tvalid)
      else $error("result without a final byte");

endmodule

bind stun_attribute_address_extractor_core saae_checker u_saae_checker (.*);

[tb/stun_attribute_address_extractor_core_test.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stun_attribute_address_extractor_core_test
// Streams STUN messages byte by byte through the extractor and checks every
// answer against a cycle-free model of the attribute walk. Two directed
// messages come first. After them come phases of random messages, some well
// formed and some noisy, cut short or malformed, under several attribute
// types and several patterns of sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
module stun_attribute_address_extractor_core_test;
   import saae_pkg::*;

   localparam int STUCK_LIMIT     = 2000;
   localparam int PHASES          = 8;
   localparam int BYTES_PER_PHASE = 180;
   localparam int HOLD_CYCLES     = 400;

   typedef enum logic [1:0] {SKIP_HEADER, ATTR_HEADER, ATTR_VALUE} parse_stage_type;

   typedef struct packed {
      logic        found;
      logic [15:0] port;
      logic [31:0] addr;
   } address_answer_type;

   // walks the message as it is accepted and queues the answer due on each final byte
   class stun_address_tracker_type;
      logic [15:0]        wanted_type;
      parse_stage_type    stage;
      logic [4:0]         header_seen;
      logic [31:0]        attr_hdr;
      logic [1:0]         attr_hdr_idx;
      logic [15:0]        value_left;
      logic [63:0]        value_bits;
      logic               hit;
      logic               decided;
      address_answer_type answers[$];
      int                 failures;

      function new();
         wanted_type = ATTR_MAPPED_ADDR;
         failures    = 0;
         clear_message();
      endfunction

      function void clear_message();
         stage        = SKIP_HEADER;
         header_seen  = '0;
         attr_hdr     = '0;
         attr_hdr_idx = '0;
         value_left   = '0;
         value_bits   = '0;
         hit          = 1'b0;
         decided      = 1'b0;
      endfunction

      function void set_wanted_type(input logic [15:0] t);
         wanted_type = t;
      endfunction

      function void note_byte(input logic [7:0] b, input logic is_final);
         address_answer_type answer;
         if (!decided) begin
            case (stage)
               SKIP_HEADER: begin
                  header_seen = header_seen + 5'd1;
                  if (header_seen >= MSG_HEADER_BYTES)
                     stage = ATTR_HEADER;
               end
               ATTR_HEADER: begin
                  attr_hdr = {attr_hdr[23:0], b};
                  if (attr_hdr_idx == 2'd3) begin
                     attr_hdr_idx = '0;
                     hit          = (attr_hdr[31:16] == wanted_type);
                     value_left   = attr_hdr[15:0];
                     value_bits   = '0;
                     // a matching type with the wrong length settles it at once
                     if (hit && attr_hdr[15:0] != ADDR_VALUE_LEN) begin
                        decided = 1'b1;
                        hit     = 1'b0;
                     end else if (attr_hdr[15:0] != 16'd0) begin
                        stage = ATTR_VALUE;
                     end
                  end else begin
                     attr_hdr_idx = attr_hdr_idx + 2'd1;
                  end
               end
               default: begin
                  value_bits = {value_bits[55:0], b};
                  value_left = value_left - 16'd1;
                  if (value_left == 16'd0) begin
                     if (hit) begin
                        decided = 1'b1;
                        hit     = (value_bits[55:48] == FAMILY_IPV4);
                     end else begin
                        stage = ATTR_HEADER;
                     end
                  end
               end
            endcase
         end
         if (is_final) begin
            answer.found = decided && hit;
            answer.port  = answer.found ? value_bits[47:32] : 16'd0;
            answer.addr  = answer.found ? value_bits[31:0] : 32'd0;
            answers.push_back(answer);
            clear_message();
         end
      endfunction

      function void check_answer(input logic found, input logic [15:0] port,
                                 input logic [31:0] addr);
         address_answer_type want;
         if (answers.size() == 0) begin
            $error("unexpected result: found %0d port %h ipv4_address %h", found, port, addr);
            failures++;
            return;
         end
         want = answers.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            failures++;
         end
         if (port !== want.port) begin
            $error("port_number: expected %h, got %h", want.port, port);
            failures++;
         end
         if (addr !== want.addr) begin
            $error("ipv4_address: expected %h, got %h", want.addr, addr);
            failures++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;   // [7:0] message_byte
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // [15:0] port_number, [47:16] ipv4_address
   logic                   rsp_tuser;         // [0] found
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [ATTR_TYPE_W-1:0] csr_data   = '0;

   stun_address_tracker_type tracker;
   logic [7:0]          msg_bytes[$];
   int                  req_idle_pct  = 0;
   int                  rsp_stall_pct = 0;
   logic                rsp_hold      = 1'b0;
   int                  bytes_sent    = 0;
   int                  stuck_cycles  = 0;

   stun_attribute_address_extractor_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_answer(rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16]);
   end

   // nothing moving on any channel for too long means the block has hung
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high between back-to-back bytes
   task automatic send_byte(input logic [7:0] b, input logic is_final);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_final;
      do @(posedge clock); while (!req_tready);
      tracker.note_byte(b, is_final);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.answers.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_attr_type(input logic [15:0] t);
      csr_valid <= 1'b1;
      csr_data  <= t;
      do @(posedge clock); while (!csr_ready);
      tracker.set_wanted_type(t);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic hold_rsp_off(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(negedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic push_attr_header(input logic [15:0] t, input logic [15:0] len);
      msg_bytes.push_back(t[15:8]);
      msg_bytes.push_back(t[7:0]);
      msg_bytes.push_back(len[15:8]);
      msg_bytes.push_back(len[7:0]);
   endtask

   task automatic push_random(input int n);
      repeat (n) msg_bytes.push_back(8'($urandom));
   endtask

   task automatic build_random_message();
      int          roll;
      int          cut;
      logic [15:0] t;
      logic [15:0] len;
      logic [7:0]  family;
      msg_bytes.delete();
      roll = $urandom_range(99);
      if (roll < 8) begin
         push_random($urandom_range(1, 40));
         return;
      end
      push_random(20);
      // attributes of other types, zero length ones included
      repeat ($urandom_range(0, 3)) begin
         t = $urandom_range(1) ? 16'($urandom_range(0, 8)) : 16'($urandom);
         if (t == tracker.wanted_type)
            t = t ^ 16'h0100;
         if ($urandom_range(19) == 0) begin
            // long value: the message ends somewhere inside it
            push_attr_header(t, 16'($urandom) | 16'h0100);
            push_random($urandom_range(0, 12));
            return;
         end
         len = 16'($urandom_range(0, 6));
         push_attr_header(t, len);
         push_random(len);
      end
      if ($urandom_range(9) != 0) begin
         roll = $urandom_range(99);
         if (roll < 85)
            len = ADDR_VALUE_LEN;
         else if (roll < 90)
            len = 16'd0;
         else if (roll < 95)
            len = 16'($urandom_range(1, 12));
         else
            len = 16'($urandom);
         push_attr_header(tracker.wanted_type, len);
         if (len == ADDR_VALUE_LEN) begin
            family = ($urandom_range(99) < 85) ? FAMILY_IPV4 : 8'($urandom);
            push_random(1);
            msg_bytes.push_back(family);
            push_random(6);
         end
      end
      // a second match after the decision must not change the answer
      if ($urandom_range(1)) begin
         push_attr_header(tracker.wanted_type, ADDR_VALUE_LEN);
         push_random(1);
         msg_bytes.push_back(FAMILY_IPV4);
         push_random(6);
      end
      push_random($urandom_range(0, 4));
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, msg_bytes.size());
         while (msg_bytes.size() > cut)
            void'(msg_bytes.pop_back());
      end
   endtask

   function automatic logic [15:0] phase_attr_type(input int p);
      case (p)
         1, 6:    return ATTR_CHANGED_ADDR;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return ATTR_MAPPED_ADDR;
         default: return 16'($urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      int phase_start;
      tracker = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // message ending inside the header
      msg_bytes.delete();
      msg_bytes.push_back(8'hFF);
      send_message();
      // full mapped address with all-ones port and address
      msg_bytes.delete();
      for (int i = 0; i < 20; i++)
         msg_bytes.push_back(i[0] ? 8'hFF : 8'h00);
      push_attr_header(ATTR_MAPPED_ADDR, ADDR_VALUE_LEN);
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(FAMILY_IPV4);
      repeat (6) msg_bytes.push_back(8'hFF);
      send_message();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            repeat (4) @(negedge clock);
            write_attr_type(phase_attr_type(p));
         end
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 45; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 45; end
            default: begin req_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         // long receiver hold-off while bytes keep coming, so the input stalls
         if (p == 4)
            fork
               hold_rsp_off(HOLD_CYCLES);
            join_none
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
            build_random_message();
            send_message();
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (tracker.failures == 0 && tracker.answers.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
